// ----- hdl/avsr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avsr_pkg: shared types and helpers for the absolute volume sync reducer
// Event codes, support codes, beat structs and the percent/absolute mappings.
// ----------------------------------------------------------------------------
package avsr_pkg;

  localparam int GEN_W = 64;
  localparam int ABS_W = 7;
  localparam int PCT_W = 7;

  // event kinds
  localparam logic [2:0] KIND_BEGIN   = 3'd0;
  localparam logic [2:0] KIND_SUPPORT = 3'd1;
  localparam logic [2:0] KIND_LOCAL   = 3'd2;
  localparam logic [2:0] KIND_REMOTE  = 3'd3;
  localparam logic [2:0] KIND_END     = 3'd4;

  // peer support codes
  localparam logic [1:0] SUPPORT_UNKNOWN = 2'd0;
  localparam logic [1:0] SUPPORT_YES     = 2'd1;

  localparam logic [7:0] PCT_MAX = 8'd100;

  // reciprocal constants, exact over the mapped input ranges
  localparam logic [27:0] Recip100   = 28'd5243;   // 2^19 / 100, rounded up
  localparam int          Recip100Sh = 19;
  localparam logic [28:0] Recip127   = 29'd16514;  // 2^21 / 127, rounded up
  localparam int          Recip127Sh = 21;

  typedef struct packed {
    logic [2:0]       kind;
    logic [GEN_W-1:0] generation;
    logic [1:0]       support;
    logic [7:0]       local_percent;
    logic             local_muted;
    logic [7:0]       remote_volume;
    logic             remote_event;
  } item_t;

  typedef struct packed {
    logic             send_remote;
    logic [ABS_W-1:0] remote_volume_out;
    logic             set_local;
    logic [PCT_W-1:0] local_percent_out;
    logic             local_mute_out;
  } result_t;

  // (p*127 + 50) / 100 for p in 0..100
  function automatic logic [ABS_W-1:0] pct_to_abs(input logic [PCT_W-1:0] pct);
    logic [13:0] num;
    logic [27:0] prod;
    num  = 14'(pct) * 14'd127 + 14'd50;
    prod = 28'(num) * Recip100;
    return prod[Recip100Sh +: ABS_W];
  endfunction

  // (v*100 + 63) / 127 for v in 0..127
  function automatic logic [PCT_W-1:0] abs_to_pct(input logic [ABS_W-1:0] v);
    logic [13:0] num;
    logic [28:0] prod;
    num  = 14'(v) * 14'd100 + 14'd63;
    prod = 29'(num) * Recip127;
    return prod[Recip127Sh +: PCT_W];
  endfunction

endpackage

// ----- hdl/avsr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avsr_if: event and result channels
// Valid/ready channels carrying one event beat or one result beat.
// ----------------------------------------------------------------------------
interface avsr_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [63:0] generation;
  logic [1:0] support;
  logic [7:0] local_percent;
  logic       local_muted;
  logic [7:0] remote_volume;
  logic       remote_event;

  modport source (output valid, kind, generation, support, local_percent, local_muted,
                  remote_volume, remote_event, input ready);
  modport sink (input valid, kind, generation, support, local_percent, local_muted,
                remote_volume, remote_event, output ready);
endinterface

interface avsr_res_if;
  logic       valid;
  logic       ready;
  logic       send_remote;
  logic [6:0] remote_volume_out;
  logic       set_local;
  logic [6:0] local_percent_out;
  logic       local_mute_out;

  modport source (output valid, send_remote, remote_volume_out, set_local,
                  local_percent_out, local_mute_out, input ready);
  modport sink (input valid, send_remote, remote_volume_out, set_local,
                local_percent_out, local_mute_out, output ready);
endinterface

// ----- hdl/avsr_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avsr_core: session state and per-event decision logic
// Holds the session registers and computes one result per event beat.
// ----------------------------------------------------------------------------
module avsr_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  avsr_pkg::item_t   item,
  output avsr_pkg::result_t res
);

  logic [63:0] gen_r, gen_nxt;
  logic        active_r, active_nxt;
  logic [1:0]  support_r, support_nxt;
  logic        known_r, known_nxt;
  logic [6:0]  pct_r, pct_nxt;
  logic        mute_r, mute_nxt;
  logic        first_r, first_nxt;
  logic        echo_r, echo_nxt;
  logic        lup_r, lup_nxt;
  logic [6:0]  last_sent_r, last_sent_nxt;
  logic [6:0]  pend_r, pend_nxt;
  logic        inbound_r, inbound_nxt;
  logic [6:0]  last_rx_r, last_rx_nxt;

  logic [63:0] diff;
  logic        is_cur;
  logic        is_newer;
  logic [6:0]  clamp;
  logic [6:0]  new_proj;
  logic [6:0]  kept_proj;
  logic [6:0]  rv;
  logic        send_req;
  logic [6:0]  send_val;

  always_comb begin
    diff      = item.generation - gen_r;
    is_cur    = (item.generation != '0) && active_r && (item.generation == gen_r);
    is_newer  = (item.generation != '0) &&
                ((gen_r == '0) || ((diff != '0) && !diff[63]));
    clamp     = (item.local_percent > avsr_pkg::PCT_MAX) ? avsr_pkg::PCT_MAX[6:0]
                                                         : item.local_percent[6:0];
    new_proj  = (item.local_muted || clamp == '0) ? '0 : avsr_pkg::pct_to_abs(clamp);
    kept_proj = (mute_r || pct_r == '0) ? '0 : avsr_pkg::pct_to_abs(pct_r);
    rv        = item.remote_volume[6:0];

    gen_nxt       = gen_r;
    active_nxt    = active_r;
    support_nxt   = support_r;
    known_nxt     = known_r;
    pct_nxt       = pct_r;
    mute_nxt      = mute_r;
    first_nxt     = first_r;
    echo_nxt      = echo_r;
    lup_nxt       = lup_r;
    last_sent_nxt = last_sent_r;
    pend_nxt      = pend_r;
    inbound_nxt   = inbound_r;
    last_rx_nxt   = last_rx_r;
    send_req      = 1'b0;
    send_val      = '0;
    res           = '0;

    case (item.kind)
      avsr_pkg::KIND_BEGIN: begin
        if (is_newer) begin
          // fresh session: everything cleared, then opened
          gen_nxt       = item.generation;
          active_nxt    = 1'b1;
          support_nxt   = item.support;
          known_nxt     = 1'b1;
          pct_nxt       = clamp;
          mute_nxt      = item.local_muted;
          first_nxt     = 1'b0;
          echo_nxt      = 1'b0;
          lup_nxt       = 1'b0;
          last_sent_nxt = '0;
          pend_nxt      = '0;
          inbound_nxt   = 1'b0;
          last_rx_nxt   = '0;
          send_req      = (item.support == avsr_pkg::SUPPORT_YES);
          send_val      = new_proj;
        end
      end
      avsr_pkg::KIND_SUPPORT: begin
        if (is_cur) begin
          support_nxt = item.support;
          if (item.support != avsr_pkg::SUPPORT_YES) begin
            first_nxt = 1'b0;
            echo_nxt  = 1'b0;
            lup_nxt   = 1'b0;
          end else if (!first_r) begin
            send_req = known_r;
            send_val = kept_proj;
          end
        end
      end
      avsr_pkg::KIND_LOCAL: begin
        if (is_cur) begin
          known_nxt = 1'b1;
          pct_nxt   = clamp;
          mute_nxt  = item.local_muted;
          if (lup_r) begin
            // callback that our own local update caused
            lup_nxt = 1'b0;
            if (new_proj == pend_r) begin
              last_sent_nxt = new_proj;
              echo_nxt      = 1'b0;
            end else begin
              send_req = (support_r == avsr_pkg::SUPPORT_YES);
              send_val = new_proj;
            end
          end else if (support_r == avsr_pkg::SUPPORT_YES &&
                       !(first_r && last_sent_r == new_proj)) begin
            send_req = 1'b1;
            send_val = new_proj;
          end
        end
      end
      avsr_pkg::KIND_REMOTE: begin
        if (is_cur && support_r == avsr_pkg::SUPPORT_YES && !item.remote_volume[7]) begin
          if (!item.remote_event) begin
            if (echo_r && rv == last_sent_r) begin
              echo_nxt = 1'b0;
            end
          end else if (!(inbound_r && rv == last_rx_r)) begin
            inbound_nxt = 1'b1;
            last_rx_nxt = rv;
            echo_nxt    = 1'b0;
            if (!(known_r && kept_proj == rv)) begin
              res.set_local         = 1'b1;
              res.local_percent_out = avsr_pkg::abs_to_pct(rv);
              res.local_mute_out    = (rv == '0);
              lup_nxt               = 1'b1;
              pend_nxt              = rv;
            end
          end
        end
      end
      avsr_pkg::KIND_END: begin
        if (is_cur) begin
          active_nxt  = 1'b0;
          support_nxt = avsr_pkg::SUPPORT_UNKNOWN;
          echo_nxt    = 1'b0;
          lup_nxt     = 1'b0;
          inbound_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (send_req) begin
      res.send_remote       = 1'b1;
      res.remote_volume_out = send_val;
      first_nxt             = 1'b1;
      echo_nxt              = 1'b1;
      last_sent_nxt         = send_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r       <= '0;
      active_r    <= 1'b0;
      support_r   <= avsr_pkg::SUPPORT_UNKNOWN;
      known_r     <= 1'b0;
      pct_r       <= '0;
      mute_r      <= 1'b0;
      first_r     <= 1'b0;
      echo_r      <= 1'b0;
      lup_r       <= 1'b0;
      last_sent_r <= '0;
      pend_r      <= '0;
      inbound_r   <= 1'b0;
      last_rx_r   <= '0;
    end else if (go) begin
      gen_r       <= gen_nxt;
      active_r    <= active_nxt;
      support_r   <= support_nxt;
      known_r     <= known_nxt;
      pct_r       <= pct_nxt;
      mute_r      <= mute_nxt;
      first_r     <= first_nxt;
      echo_r      <= echo_nxt;
      lup_r       <= lup_nxt;
      last_sent_r <= last_sent_nxt;
      pend_r      <= pend_nxt;
      inbound_r   <= inbound_nxt;
      last_rx_r   <= last_rx_nxt;
    end
  end

endmodule

// ----- hdl/absolute_volume_sync_reducer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// absolute_volume_sync_reducer: local/remote absolute volume synchronizer
// Path: an accepted event beat is held in the event register, then passes
//   through the decision logic into the result register that drives out_bus.
// Throughput: one event beat per cycle; the event register stalls only
//   while a result beat waits and out_bus.ready is low.
// Reset: synchronous active-low rst_n clears the session state and both
//   valid flags; exactly one result beat follows every accepted event.
// ----------------------------------------------------------------------------
module absolute_volume_sync_reducer (
  input  logic clk,
  input  logic rst_n,
  avsr_evt_if.sink   in_bus,
  avsr_res_if.source out_bus
);

  // event register
  logic              evt_vld_r;
  avsr_pkg::item_t   evt_r;
  // result register
  logic              res_vld_r;
  avsr_pkg::result_t res_r;

  avsr_pkg::result_t res_nxt;
  logic              res_free;
  logic              advance;
  logic              in_take;

  // the result slot frees up when it is empty or being taken this cycle
  assign res_free = !res_vld_r || out_bus.ready;
  // the registered event moves into the result register
  assign advance  = evt_vld_r && res_free;
  assign in_bus.ready = !evt_vld_r || advance;
  assign in_take  = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_vld_r <= 1'b0;
    end else if (in_bus.ready) begin
      evt_vld_r <= in_bus.valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      evt_r.kind          <= in_bus.kind;
      evt_r.generation    <= in_bus.generation;
      evt_r.support       <= in_bus.support;
      evt_r.local_percent <= in_bus.local_percent;
      evt_r.local_muted   <= in_bus.local_muted;
      evt_r.remote_volume <= in_bus.remote_volume;
      evt_r.remote_event  <= in_bus.remote_event;
    end
  end

  // session state updates only when an event leaves the event register
  avsr_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (advance),
    .item  (evt_r),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (res_free) begin
      res_vld_r <= evt_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid             = res_vld_r;
  assign out_bus.send_remote       = res_r.send_remote;
  assign out_bus.remote_volume_out = res_r.remote_volume_out;
  assign out_bus.set_local         = res_r.set_local;
  assign out_bus.local_percent_out = res_r.local_percent_out;
  assign out_bus.local_mute_out    = res_r.local_mute_out;

endmodule

// ----- hdl/avsr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avsr_checker: port-level checks for the volume sync reducer
// Watches the result channel for protocol and field consistency.
// ----------------------------------------------------------------------------
module avsr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       send_remote,
  input logic [6:0] remote_volume_out,
  input logic       set_local,
  input logic [6:0] local_percent_out,
  input logic       local_mute_out
);

  // no result beat right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(send_remote) &&
    $stable(remote_volume_out) && $stable(set_local) &&
    $stable(local_percent_out) && $stable(local_mute_out))
    else $error("stalled result beat changed");

  // one event never drives both directions
  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(send_remote && set_local))
    else $error("send and set in one beat");

  // unused fields stay zero
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (send_remote || remote_volume_out == 7'd0) &&
    (set_local || (local_percent_out == 7'd0 && !local_mute_out)))
    else $error("field set without its request");

  // mapped local percent within range, mute only at zero
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && set_local |-> local_percent_out <= 7'd100 &&
    (!local_mute_out || local_percent_out == 7'd0))
    else $error("local percent out of range");

endmodule

bind absolute_volume_sync_reducer avsr_checker u_avsr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .send_remote       (out_bus.send_remote),
  .remote_volume_out (out_bus.remote_volume_out),
  .set_local         (out_bus.set_local),
  .local_percent_out (out_bus.local_percent_out),
  .local_mute_out    (out_bus.local_mute_out)
);
